// File: src/srec_pkg.sv
// Shared types, constants and helpers for the S1/S9 record emitter.
// Used by srec_ctrl, srec_dp and the top level srecord_s1_s9_emitter_core.
package srec_pkg;

  // Default number of data bytes per S1 record
  localparam int RECORD_BYTES_DEF = 32;

  // Input action codes (carried on in_tuser)
  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_FLUSH = 2'd1;
  localparam logic [1:0] ACT_END   = 2'd2;

  // ASCII characters used in records
  localparam logic [7:0] CH_S  = 8'h53;  // 'S'
  localparam logic [7:0] CH_1  = 8'h31;  // '1'
  localparam logic [7:0] CH_9  = 8'h39;  // '9'
  localparam logic [7:0] CH_NL = 8'h0A;  // newline
  localparam logic [7:0] CH_NUL = 8'h00;

  // Count overhead bytes: two address bytes plus the checksum byte
  localparam logic [7:0] REC_OVERHEAD = 8'd3;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_COUNT,
    ST_ADDR_HI,
    ST_ADDR_LO,
    ST_DATA,
    ST_SUM,
    ST_NL
  } state_t;

  // Which part of the record goes into the output register
  typedef enum logic [2:0] {
    PC_HEAD,
    PC_COUNT,
    PC_ADDR_HI,
    PC_ADDR_LO,
    PC_DATA,
    PC_SUM,
    PC_NL
  } piece_t;

  // Controller to datapath commands
  typedef struct packed {
    logic   add_byte;    // write data byte to buffer, bump held count
    logic   start_s1;    // capture S1 record header values
    logic   start_s9;    // capture S9 record header values
    logic   clear_held;  // held count back to zero
    logic   load_addr;   // record address takes next_address
    logic   load;        // load output register with current piece
    piece_t piece;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic fill;       // adding one more byte fills the buffer
    logic held_zero;  // no bytes held
    logic is_s9;      // record being emitted is the S9 end record
    logic data_last;  // current data byte is the last one of the record
    logic slot_free;  // output register can take a new pair
  } stat_t;

  // Upper-case hex digit
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h37 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// File: src/srecord_s1_s9_emitter_core.sv
// Top level of the S1/S9 record emitter: controller plus datapath.
// Depends on srec_pkg, srec_ctrl and srec_dp.
//
// Usage:
//  - Input stream: in_tuser selects the action (add byte, flush, end record),
//    in_tdata carries the data byte and the next record address.
//  - Output stream: one transaction per character pair; out_tuser flags a
//    valid second character, out_tlast marks the newline closing a record.
//  - cfg_we/cfg_wdata set the entry point placed in the S9 record; write it
//    only while the block is idle.
// Timing:
//  - An add that does not fill the buffer, a flush with no bytes held and an
//    unused action leave the block idle with in_tready high.
//  - An item that emits a record sends n + 6 pairs for an S1 record of n
//    bytes, 6 for S9, one pair per cycle while the receiver does not stall,
//    from the sequencer into the single output register. in_tready is low
//    meanwhile.
// Reset clears the held count, the record address and the entry point.
// A receiver stall holds the output register and pauses the sequencer; the
// buffer contents need no clearing since only written entries are read.
module srecord_s1_s9_emitter_core #(
  parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] data_byte, [23:8] next_address
  input  logic [1:0]  in_tuser,   // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_first, [15:8] char_second
  output logic        out_tuser,  // [0] pair_valid
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import srec_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  srec_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  srec_dp #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_data_byte    (in_tdata[7:0]),
    .in_next_address (in_tdata[23:8]),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .cmd             (cmd),
    .stat            (stat),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .out_tlast       (out_tlast)
  );

endmodule

// File: src/srec_ctrl.sv
// Record sequencer state machine for the S1/S9 record emitter.
// Depends on srec_pkg for state, command and status types.
module srec_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  logic [1:0]     in_action,
  input  srec_pkg::stat_t stat,
  output srec_pkg::cmd_t  cmd
);
  import srec_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  // Input is only taken while idle
  assign accept = in_tvalid && (state_r == ST_IDLE);

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_ADD:   if (stat.fill) state_nxt = ST_HEAD;
            ACT_FLUSH: if (!stat.held_zero) state_nxt = ST_HEAD;
            ACT_END:   state_nxt = ST_HEAD;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_HEAD:    if (stat.slot_free) state_nxt = ST_COUNT;
      ST_COUNT:   if (stat.slot_free) state_nxt = ST_ADDR_HI;
      ST_ADDR_HI: if (stat.slot_free) state_nxt = ST_ADDR_LO;
      ST_ADDR_LO: if (stat.slot_free) state_nxt = stat.is_s9 ? ST_SUM : ST_DATA;
      ST_DATA:    if (stat.slot_free && stat.data_last) state_nxt = ST_SUM;
      ST_SUM:     if (stat.slot_free) state_nxt = ST_NL;
      ST_NL:      if (stat.slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_tready      = 1'b0;
    cmd.add_byte   = 1'b0;
    cmd.start_s1   = 1'b0;
    cmd.start_s9   = 1'b0;
    cmd.clear_held = 1'b0;
    cmd.load_addr  = 1'b0;
    cmd.load       = 1'b0;
    cmd.piece      = PC_HEAD;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (accept) begin
          case (in_action)
            ACT_ADD: begin
              cmd.add_byte = 1'b1;
              if (stat.fill) begin
                cmd.start_s1   = 1'b1;
                cmd.clear_held = 1'b1;
                cmd.load_addr  = 1'b1;
              end
            end
            ACT_FLUSH: begin
              cmd.start_s1   = !stat.held_zero;
              cmd.clear_held = 1'b1;
              cmd.load_addr  = 1'b1;
            end
            ACT_END: cmd.start_s9 = 1'b1;
            default: ;
          endcase
        end
      end
      ST_HEAD: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_HEAD;
      end
      ST_COUNT: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_COUNT;
      end
      ST_ADDR_HI: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_ADDR_HI;
      end
      ST_ADDR_LO: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_ADDR_LO;
      end
      ST_DATA: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_DATA;
      end
      ST_SUM: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_SUM;
      end
      ST_NL: begin
        cmd.load  = stat.slot_free;
        cmd.piece = PC_NL;
      end
      default: ;
    endcase
  end

endmodule

// File: src/srec_dp.sv
// Datapath of the S1/S9 record emitter: byte buffer, address and count
// registers, checksum, hex formatting and the output register. Uses srec_pkg.
module srec_dp #(
  parameter int RECORD_BYTES = srec_pkg::RECORD_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [7:0]      in_data_byte,
  input  logic [15:0]     in_next_address,
  input  logic            cfg_we,
  input  logic [15:0]     cfg_wdata,
  input  srec_pkg::cmd_t  cmd,
  output srec_pkg::stat_t stat,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic            out_tuser,
  output logic            out_tlast
);
  import srec_pkg::*;

  localparam int CW = $clog2(RECORD_BYTES + 1);
  localparam int AW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(RECORD_BYTES);

  // Byte buffer
  logic [7:0] mem [RECORD_BYTES];
  logic [7:0] rd_data_r;

  logic [CW-1:0] held_r, held_nxt, held_inc;
  logic [15:0]   rec_addr_r, rec_addr_nxt;
  logic [15:0]   entry_r;
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt, rd_cnt_inc;
  logic [CW-1:0] n_r;
  logic [7:0]    count_r;
  logic [15:0]   addr_r;
  logic [7:0]    sum_r;
  logic          is_s9_r;
  logic          out_valid_r;
  logic [15:0]   out_data_r;
  logic          out_user_r;
  logic          out_last_r;
  logic [CW-1:0] n_start;
  logic [7:0]    count_start;
  logic [15:0]   addr_start;
  logic [7:0]    pair_byte;
  logic [15:0]   pair_data;
  logic          slot_free;

  assign held_inc   = held_r + CW'(1);
  assign rd_cnt_inc = rd_cnt_r + CW'(1);
  assign slot_free  = !out_valid_r || out_tready;

  // Status to controller
  assign stat.fill      = (held_inc == FULL_CNT);
  assign stat.held_zero = (held_r == '0);
  assign stat.is_s9     = is_s9_r;
  assign stat.data_last = (rd_cnt_inc == n_r);
  assign stat.slot_free = slot_free;

  // Buffer write on add, registered read at the next read index
  always_ff @(posedge clk) begin
    if (cmd.add_byte) begin
      mem[held_r[AW-1:0]] <= in_data_byte;
    end
    rd_data_r <= mem[rd_cnt_nxt[AW-1:0]];
  end

  // Held count and record address
  always_comb begin
    held_nxt = held_r;
    if (cmd.clear_held) begin
      held_nxt = '0;
    end else if (cmd.add_byte) begin
      held_nxt = held_inc;
    end
    rec_addr_nxt = cmd.load_addr ? in_next_address : rec_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r     <= '0;
      rec_addr_r <= '0;
      entry_r    <= '0;
    end else begin
      held_r     <= held_nxt;
      rec_addr_r <= rec_addr_nxt;
      if (cfg_we) begin
        entry_r <= cfg_wdata;
      end
    end
  end

  // Record header values captured at start
  assign n_start     = cmd.add_byte ? held_inc : held_r;
  assign count_start = cmd.start_s9 ? REC_OVERHEAD : 8'(n_start) + REC_OVERHEAD;
  assign addr_start  = cmd.start_s9 ? entry_r : rec_addr_r;

  // Read index over the held bytes
  always_comb begin
    rd_cnt_nxt = rd_cnt_r;
    if (cmd.start_s1 || cmd.start_s9) begin
      rd_cnt_nxt = '0;
    end else if (cmd.load && cmd.piece == PC_DATA) begin
      rd_cnt_nxt = rd_cnt_inc;
    end
  end

  // Record registers and running checksum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
      is_s9_r  <= 1'b0;
    end else begin
      rd_cnt_r <= rd_cnt_nxt;
      if (cmd.start_s1 || cmd.start_s9) begin
        is_s9_r <= cmd.start_s9;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_s1 || cmd.start_s9) begin
      n_r     <= n_start;
      count_r <= count_start;
      addr_r  <= addr_start;
      sum_r   <= count_start + addr_start[15:8] + addr_start[7:0];
    end else if (cmd.load && cmd.piece == PC_DATA) begin
      sum_r <= sum_r + rd_data_r;
    end
  end

  // Character pair for the current piece
  always_comb begin
    pair_byte = 8'h00;
    case (cmd.piece)
      PC_COUNT:   pair_byte = count_r;
      PC_ADDR_HI: pair_byte = addr_r[15:8];
      PC_ADDR_LO: pair_byte = addr_r[7:0];
      PC_DATA:    pair_byte = rd_data_r;
      PC_SUM:     pair_byte = ~sum_r;
      default:    pair_byte = 8'h00;
    endcase
    case (cmd.piece)
      PC_HEAD: pair_data = {is_s9_r ? CH_9 : CH_1, CH_S};
      PC_NL:   pair_data = {CH_NUL, CH_NL};
      default: pair_data = {hex_char(pair_byte[3:0]), hex_char(pair_byte[7:4])};
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_data_r <= pair_data;
      out_user_r <= (cmd.piece != PC_NL);
      out_last_r <= (cmd.piece == PC_NL);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for srecord_s1_s9_emitter_core: streams add/flush/end actions,
// predicts every S1/S9 character pair in-bench and checks each output transaction.
// Depends on srec_pkg and the srecord_s1_s9_emitter_core RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import srec_pkg::*;

  localparam int          RECORD_BYTES   = RECORD_BYTES_DEF;
  localparam logic [1:0]  ACT_UNUSED     = 2'd3;
  localparam logic [7:0]  ASCII_ZERO     = 8'h30;
  localparam logic [7:0]  ASCII_A        = 8'h41;
  localparam int          LONG_HOLD      = 600;
  localparam int          DRAIN_SLACK    = 8;
  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          PHASE_ITEMS    = 95;

  // One input action and one output character pair
  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  data_byte;
    logic [15:0] next_address;
  } action_t;

  typedef struct packed {
    logic [7:0] char_first;
    logic [7:0] char_second;
    logic       pair_valid;
    logic       last;
  } char_pair_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] data_byte, [23:8] next_address
  logic [1:0]  in_tuser = '0;   // [1:0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] char_first, [15:8] char_second
  logic        out_tuser;       // [0] pair_valid
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  srecord_s1_s9_emitter_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and expected character pairs
  action_t    action_q[$];
  char_pair_t expected_pairs[$];

  // Encoder state mirror
  logic [7:0]  byte_store [RECORD_BYTES];
  int          held_n = 0;
  logic [15:0] rec_addr = '0;
  logic [15:0] entry_pt = '0;

  int errors = 0;
  int s1_records = 0;
  int s9_records = 0;
  int ignored_actions = 0;
  int accepted_actions = 0;
  int pairs_checked = 0;
  int hold_req = 0;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    return (nib > 4'd9) ? ASCII_A + 8'(nib - 4'd10) : ASCII_ZERO + 8'(nib);
  endfunction

  task automatic push_pair(input logic [7:0] c1, input logic [7:0] c2,
                           input logic pv, input logic lst);
    expected_pairs.push_back('{c1, c2, pv, lst});
  endtask

  task automatic push_hex(input logic [7:0] b);
    push_pair(hex_digit(b[7:4]), hex_digit(b[3:0]), 1'b1, 1'b0);
  endtask

  // S1 record of the held bytes (if any), then move to the next address
  task automatic emit_s1(input logic [15:0] next_addr);
    logic [7:0] cnt;
    logic [7:0] sum;
    if (held_n > 0) begin
      cnt = 8'(held_n) + REC_OVERHEAD;
      sum = cnt + rec_addr[15:8] + rec_addr[7:0];
      push_pair(CH_S, CH_1, 1'b1, 1'b0);
      push_hex(cnt);
      push_hex(rec_addr[15:8]);
      push_hex(rec_addr[7:0]);
      for (int i = 0; i < held_n; i++) begin
        sum += byte_store[i];
        push_hex(byte_store[i]);
      end
      push_hex(~sum);
      push_pair(CH_NL, CH_NUL, 1'b0, 1'b1);
      s1_records++;
    end
    held_n = 0;
    rec_addr = next_addr;
  endtask

  // S9 end record; held bytes and address are left alone
  task automatic emit_s9();
    logic [7:0] sum;
    sum = REC_OVERHEAD + entry_pt[15:8] + entry_pt[7:0];
    push_pair(CH_S, CH_9, 1'b1, 1'b0);
    push_hex(REC_OVERHEAD);
    push_hex(entry_pt[15:8]);
    push_hex(entry_pt[7:0]);
    push_hex(~sum);
    push_pair(CH_NL, CH_NUL, 1'b0, 1'b1);
    s9_records++;
  endtask

  // Expected pairs caused by one accepted action
  task automatic encode_action(input action_t a);
    case (a.action)
      ACT_ADD: begin
        byte_store[held_n] = a.data_byte;
        held_n++;
        if (held_n >= RECORD_BYTES) emit_s1(a.next_address);
      end
      ACT_FLUSH: emit_s1(a.next_address);
      ACT_END:   emit_s9();
      default:   ignored_actions++;
    endcase
  endtask

  // Driver: bursts of random length separated by random gaps
  int burst_left = 1;
  int gap_left = 0;
  action_t cur_act = '0;

  always @(posedge clk) begin : driver
    action_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        encode_action(cur_act);
        accepted_actions++;
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (action_q.size() > 0) begin
          nxt = action_q.pop_front();
          cur_act <= nxt;
          in_tdata <= {nxt.next_address, nxt.data_byte};
          in_tuser <= nxt.action;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern changes every so often; long hold-off on request
  int hold_taken = 0;
  int hold_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_phase = 0;

  always @(posedge clk) begin : receiver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_taken != hold_req) begin
      hold_taken <= hold_req;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_mode_left <= $urandom_range(10, 120);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        2:       out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_phase % 5) < 3;
      endcase
    end
  end

  // Monitor: compare each output transaction with the oldest expectation
  always @(posedge clk) begin : monitor
    char_pair_t got;
    char_pair_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tdata[7:0], out_tdata[15:8], out_tuser, out_tlast};
      if (expected_pairs.size() == 0) begin
        $error("unexpected pair: first=%h second=%h pv=%b last=%b",
               got.char_first, got.char_second, got.pair_valid, got.last);
        errors++;
      end else begin
        want = expected_pairs.pop_front();
        if (got.char_first !== want.char_first) begin
          $error("char_first: expected %h, got %h", want.char_first, got.char_first);
          errors++;
        end
        if (got.char_second !== want.char_second) begin
          $error("char_second: expected %h, got %h", want.char_second, got.char_second);
          errors++;
        end
        if (got.pair_valid !== want.pair_valid) begin
          $error("pair_valid: expected %b, got %b", want.pair_valid, got.pair_valid);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, got.last);
          errors++;
        end
        pairs_checked++;
      end
    end
  end

  // Watchdog: cycles without any transaction
  int idle_cycles = 0;

  always @(posedge clk) begin : watchdog
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stimulus helpers
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] rand_addr();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic queue_action(input logic [1:0] act, input logic [7:0] b,
                              input logic [15:0] addr);
    action_q.push_back('{act, b, addr});
  endtask

  // Run of data bytes, optionally closed by a flush
  task automatic queue_byte_run(input int n, input bit close, inout int counted);
    for (int i = 0; i < n; i++) queue_action(ACT_ADD, rand_byte(), rand_addr());
    counted += n;
    if (close) begin
      queue_action(ACT_FLUSH, rand_byte(), rand_addr());
      counted++;
    end
  endtask

  // Mostly well-formed record sequences with random content, some noise
  task automatic queue_random_phase(input int goal);
    int counted;
    int r;
    int n;
    counted = 0;
    while (counted < goal) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        case ($urandom_range(0, 7))
          0:       n = RECORD_BYTES;
          1:       n = RECORD_BYTES + $urandom_range(1, 8);
          2:       n = $urandom_range(1, 40);
          default: n = $urandom_range(1, 8);
        endcase
        queue_byte_run(n, $urandom_range(0, 3) != 0, counted);
      end else if (r < 70) begin
        queue_action(ACT_END, rand_byte(), rand_addr());
        counted++;
      end else if (r < 80) begin
        queue_action(ACT_FLUSH, rand_byte(), rand_addr());
        counted++;
      end else if (r < 85) begin
        queue_action(ACT_UNUSED, rand_byte(), rand_addr());
      end else begin
        queue_action(ACT_ADD, rand_byte(), rand_addr());
        counted++;
      end
    end
  endtask

  // Sender pause: everything accepted and every pair returned
  task automatic wait_drained();
    do @(negedge clk);
    while (action_q.size() != 0 || in_tvalid || expected_pairs.size() != 0);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  // Entry point write, only while idle
  task automatic write_entry(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    entry_pt = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Test sequence
  initial begin : sequencer
    int dummy;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: reset entry point, empty flush, byte extremes, end with bytes held,
    // unused action code
    queue_action(ACT_END, 8'h00, 16'h0000);
    queue_action(ACT_FLUSH, 8'hFF, 16'hFFFF);
    queue_action(ACT_ADD, 8'h00, 16'h0000);
    queue_action(ACT_ADD, 8'hFF, 16'hFFFF);
    queue_action(ACT_ADD, 8'hA5, 16'h5A5A);
    queue_action(ACT_FLUSH, 8'h00, 16'h0000);
    queue_action(ACT_UNUSED, 8'hFF, 16'hFFFF);
    queue_action(ACT_ADD, 8'h5A, 16'hFFFF);
    queue_action(ACT_END, 8'hFF, 16'hFFFF);
    queue_action(ACT_FLUSH, 8'h00, 16'h8001);
    queue_action(ACT_FLUSH, 8'h00, 16'h1234);
    queue_action(ACT_ADD, 8'h3C, 16'h0000);
    queue_action(ACT_UNUSED, 8'h00, 16'h0000);
    queue_action(ACT_FLUSH, 8'hFF, 16'hFFFF);
    wait_drained();

    // Max entry point; a full buffer forces the automatic record first
    write_entry(16'hFFFF);
    dummy = 0;
    queue_byte_run(RECORD_BYTES, 1'b0, dummy);
    queue_action(ACT_END, 8'h00, 16'h0000);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    // Random entry point; receiver holds off while the sender keeps offering
    write_entry(16'($urandom_range(0, 65535)));
    queue_random_phase(PHASE_ITEMS);
    hold_req = hold_req + 1;
    wait_drained();

    // Zero entry point
    write_entry(16'h0000);
    queue_random_phase(PHASE_ITEMS);
    wait_drained();

    repeat (16) @(posedge clk);
    $display("Run covered %0d actions (%0d unused codes) under four entry point settings",
             accepted_actions, ignored_actions);
    $display("  %0d S1 and %0d S9 records, %0d pairs checked",
             s1_records, s9_records, pairs_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
